// ----- rtl/vif_pkg.sv -----
// Shared types and constants for the versatile interface adapter.
package vif_pkg;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_WRITE    = 3'd1,
		OP_TICK     = 3'd2,
		OP_SERIAL   = 3'd3,
		OP_SHIFT_RX = 3'd4
	} op_t;

	localparam logic [3:0] RS_PORT_B = 4'd0;
	localparam logic [3:0] RS_PORT_A = 4'd1;
	localparam logic [3:0] RS_T1_LO  = 4'd4;
	localparam logic [3:0] RS_T1_HI  = 4'd5;
	localparam logic [3:0] RS_T2_LO  = 4'd8;
	localparam logic [3:0] RS_T2_HI  = 4'd9;
	localparam logic [3:0] RS_SR     = 4'd10;
	localparam logic [3:0] RS_IFR    = 4'd13;
	localparam logic [3:0] RS_IER    = 4'd14;

	localparam logic [7:0] FLAG_T1 = 8'h40;
	localparam logic [7:0] FLAG_T2 = 8'h20;
	localparam logic [7:0] FLAG_SR = 8'h10;

	localparam logic [3:0] SHIFT_STEPS = 4'd8;

endpackage

// ----- rtl/vif_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module vif_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/versatile_interface_adapter.sv -----
// Top level of the versatile interface adapter: register file, timers, shifter and rx FIFO.
//
// Takes one bus read, bus write, timer tick, serial character or received shift byte per
// cycle unless item_stall holds it back behind a stalled result, and returns exactly one
// result per item. An accepted item waits in the input register until the result register
// is free, and its result is then registered there. The single write port and single
// registered read port of the rx FIFO memory set no limit on that rate, since the read
// address always tracks the next tail and a push into an empty FIFO is forwarded to an
// immediately following port A read. The FIFO holds FIFO_DEPTH-1 characters; a character
// pushed while it is full is dropped. Timer registers read as zero; reading port A pops
// a non-empty FIFO, writing port B with bit 7 set transmits port A.
module versatile_interface_adapter #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [2:0] opcode,
	input  logic [3:0] register_select,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] read_data,
	output logic       tx_valid,
	output logic [7:0] tx_byte
);

	import vif_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(FIFO_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	// input stage
	logic       valid_s1;
	logic [2:0] opcode_s1;
	logic [3:0] rsel_s1;
	logic [7:0] data_s1;

	// result register
	logic       res_valid_q;
	logic [7:0] read_data_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;

	// architectural state
	logic [7:0]    port_b_q, port_a_q;
	logic [7:0]    plain_q [16];
	logic [15:0]   t1_cnt_q, t1_lat_q, t2_cnt_q, t2_lat_q;
	logic [7:0]    flag_q;
	logic [6:0]    ier_q;
	logic [7:0]    shifter_q;
	logic [3:0]    scnt_q;
	logic          shifting_q;
	logic          rx_ready_q;
	logic [PW-1:0] head_q, tail_q;

	// FIFO forwarding
	logic       wr_hit_q;
	logic [7:0] wr_byp_q;

	logic [7:0]    port_b_d, port_a_d;
	logic [7:0]    plain_d [16];
	logic [15:0]   t1_cnt_d, t1_lat_d, t2_cnt_d, t2_lat_d;
	logic [7:0]    flag_d;
	logic [6:0]    ier_d;
	logic [7:0]    shifter_d;
	logic [3:0]    scnt_d;
	logic          shifting_d;
	logic          rx_ready_d;
	logic [PW-1:0] head_d, tail_d;
	logic [7:0]    rd_val;
	logic          tx_v;
	logic [7:0]    tx_b;
	logic          fifo_we;
	logic [PW-1:0] head_nx;
	logic [7:0]    ram_rdata;
	logic [7:0]    fifo_out;
	logic          fifo_nonempty;
	logic          advance;
	logic          exec;
	logic          accept;

	assign advance    = !res_valid_q || !result_stall;
	assign exec       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	assign head_nx       = ptr_next(head_q);
	assign fifo_nonempty = (head_q != tail_q);
	assign fifo_out      = wr_hit_q ? wr_byp_q : ram_rdata;

	always_comb begin
		port_b_d   = port_b_q;
		port_a_d   = port_a_q;
		plain_d    = plain_q;
		t1_cnt_d   = t1_cnt_q;
		t1_lat_d   = t1_lat_q;
		t2_cnt_d   = t2_cnt_q;
		t2_lat_d   = t2_lat_q;
		flag_d     = flag_q;
		ier_d      = ier_q;
		shifter_d  = shifter_q;
		scnt_d     = scnt_q;
		shifting_d = shifting_q;
		rx_ready_d = rx_ready_q;
		head_d     = head_q;
		tail_d     = tail_q;
		rd_val     = 8'h00;
		tx_v       = 1'b0;
		tx_b       = 8'h00;
		fifo_we    = 1'b0;
		if (exec) begin
			case (op_t'(opcode_s1))
				OP_READ: begin
					case (rsel_s1)
						RS_PORT_B: rd_val = {port_b_q[7], fifo_nonempty, port_b_q[5:0]};
						RS_PORT_A: begin
							if (fifo_nonempty) begin
								rd_val = fifo_out;
								tail_d = ptr_next(tail_q);
							end else begin
								rd_val = port_a_q;
							end
						end
						RS_T1_LO, RS_T1_HI, RS_T2_LO, RS_T2_HI: rd_val = 8'h00;
						RS_SR: begin
							if (rx_ready_q) begin
								rd_val     = shifter_q;
								rx_ready_d = 1'b0;
								flag_d     = flag_q & ~FLAG_SR;
							end
						end
						RS_IFR:  rd_val = flag_q;
						RS_IER:  rd_val = {1'b1, ier_q};
						default: rd_val = plain_q[rsel_s1];
					endcase
				end
				OP_WRITE: begin
					case (rsel_s1)
						RS_PORT_B: begin
							if (data_s1[7]) begin
								tx_v = 1'b1;
								tx_b = port_a_q;
							end
							port_b_d = data_s1;
						end
						RS_PORT_A: port_a_d = data_s1;
						RS_T1_LO:  t1_lat_d = {t1_lat_q[15:8], data_s1};
						RS_T1_HI: begin
							t1_lat_d = {data_s1, t1_lat_q[7:0]};
							t1_cnt_d = {data_s1, t1_lat_q[7:0]};
						end
						RS_T2_LO:  t2_lat_d = {t2_lat_q[15:8], data_s1};
						RS_T2_HI: begin
							t2_lat_d = {data_s1, t2_lat_q[7:0]};
							t2_cnt_d = {data_s1, t2_lat_q[7:0]};
						end
						RS_SR: begin
							shifter_d  = data_s1;
							scnt_d     = SHIFT_STEPS;
							shifting_d = 1'b1;
							flag_d     = flag_q & ~FLAG_SR;
						end
						RS_IFR: flag_d = flag_q & ~data_s1;
						RS_IER: begin
							if (data_s1[7]) begin
								ier_d = ier_q | data_s1[6:0];
							end else begin
								ier_d = ier_q & ~data_s1[6:0];
							end
						end
						default: plain_d[rsel_s1] = data_s1;
					endcase
				end
				OP_TICK: begin
					if (t1_cnt_q != 16'h0000) begin
						t1_cnt_d = t1_cnt_q - 16'h0001;
						if (t1_cnt_q == 16'h0001) begin
							flag_d = flag_d | FLAG_T1;
						end
					end
					if (t2_cnt_q != 16'h0000) begin
						t2_cnt_d = t2_cnt_q - 16'h0001;
						if (t2_cnt_q == 16'h0001) begin
							flag_d = flag_d | FLAG_T2;
						end
					end
					if (shifting_q) begin
						shifter_d = {shifter_q[6:0], 1'b0};
						scnt_d    = scnt_q - 4'd1;
						if (scnt_q == 4'd1) begin
							shifting_d = 1'b0;
							flag_d     = flag_d | FLAG_SR;
						end
					end
				end
				OP_SERIAL: begin
					// drop the character when full
					if (head_nx != tail_q) begin
						fifo_we = 1'b1;
						head_d  = head_nx;
					end
				end
				OP_SHIFT_RX: begin
					shifter_d  = data_s1;
					rx_ready_d = 1'b1;
					flag_d     = flag_q | FLAG_SR;
				end
				default: ;
			endcase
		end
	end

	// read address follows the tail the next item will see
	vif_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_fifo_ram (
		.clk  (clk),
		.we   (fifo_we),
		.waddr(head_q),
		.wdata(data_s1),
		.raddr(tail_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			wr_hit_q    <= 1'b0;
			port_b_q    <= '0;
			port_a_q    <= '0;
			plain_q     <= '{default: '0};
			t1_cnt_q    <= '0;
			t1_lat_q    <= '0;
			t2_cnt_q    <= '0;
			t2_lat_q    <= '0;
			flag_q      <= '0;
			ier_q       <= '0;
			shifter_q   <= '0;
			scnt_q      <= '0;
			shifting_q  <= 1'b0;
			rx_ready_q  <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !exec);
			res_valid_q <= exec || (res_valid_q && result_stall);
			wr_hit_q    <= fifo_we && (head_q == tail_d);
			port_b_q    <= port_b_d;
			port_a_q    <= port_a_d;
			plain_q     <= plain_d;
			t1_cnt_q    <= t1_cnt_d;
			t1_lat_q    <= t1_lat_d;
			t2_cnt_q    <= t2_cnt_d;
			t2_lat_q    <= t2_lat_d;
			flag_q      <= flag_d;
			ier_q       <= ier_d;
			shifter_q   <= shifter_d;
			scnt_q      <= scnt_d;
			shifting_q  <= shifting_d;
			rx_ready_q  <= rx_ready_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			rsel_s1   <= register_select;
			data_s1   <= data_byte;
		end
		if (exec) begin
			read_data_q <= rd_val;
			tx_valid_q  <= tx_v;
			tx_byte_q   <= tx_b;
		end
		wr_byp_q <= data_s1;
	end

	assign result_valid = res_valid_q;
	assign read_data    = read_data_q;
	assign tx_valid     = tx_valid_q;
	assign tx_byte      = tx_byte_q;

	// a forwarded push always leaves the FIFO non-empty
	a_fwd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		wr_hit_q |-> (head_q != tail_q))
		else $error("FIFO forwarding flagged while FIFO empty");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		shifting_q |-> (scnt_q != 4'd0))
		else $error("shifter running with zero step count");

	a_tx_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && tx_valid) |-> (read_data == 8'h00))
		else $error("transmit result carries read data");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && res_valid_q))
		else $error("input stalled without a held transfer");

endmodule

// ----- tb/sv/tb_versatile_interface_adapter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the versatile interface adapter: directed rows, then random bus traffic.
module tb_versatile_interface_adapter;
	import vif_pkg::*;

	localparam int FIFO_DEPTH = 64;
	localparam int LONG_HOLD_CYCLES = 48;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTED = 30;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} bus_result_t;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] rs;
		logic [7:0] data;
		logic       fixed;
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} table_row_t;

	// Typed-in results only where they are obvious; the rest come from the predictor.
	localparam table_row_t DIRECTED_ROWS [26] = '{
		'{OP_READ,     RS_IFR,    8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_READ,     RS_IER,    8'h00, 1'b1, 8'h80, 1'b0, 8'h00},
		'{OP_READ,     RS_PORT_B, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_READ,     RS_PORT_A, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_PORT_A, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_PORT_B, 8'h80, 1'b1, 8'h00, 1'b1, 8'hFF},
		'{OP_WRITE,    RS_PORT_B, 8'h7F, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_READ,     RS_PORT_B, 8'h00, 1'b1, 8'h3F, 1'b0, 8'h00},
		'{OP_WRITE,    RS_T1_LO,  8'h03, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_T1_HI,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_T2_LO,  8'h01, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_T2_HI,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_READ,     RS_T1_HI,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_TICK,     4'h0,      8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_TICK,     4'hF,      8'hFF, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_TICK,     4'h0,      8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_READ,     RS_IFR,    8'h00, 1'b1, 8'h60, 1'b0, 8'h00},
		'{OP_WRITE,    RS_IFR,    8'h20, 1'b1, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_SR,     8'hA5, 1'b0, 8'h00, 1'b0, 8'h00},
		'{OP_SHIFT_RX, RS_SR,     8'h3C, 1'b0, 8'h00, 1'b0, 8'h00},
		'{OP_READ,     RS_SR,     8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_IER,    8'hFF, 1'b0, 8'h00, 1'b0, 8'h00},
		'{OP_WRITE,    RS_IER,    8'h55, 1'b0, 8'h00, 1'b0, 8'h00},
		'{OP_SERIAL,   4'h0,      8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
		'{OP_READ,     RS_PORT_A, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
		'{OP_SPARE_LAST, 4'hF,    8'hFF, 1'b1, 8'h00, 1'b0, 8'h00}
	};

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic [2:0] opcode;
	logic [3:0] register_select;
	logic [7:0] data_byte;
	logic       result_valid;
	logic       result_stall;
	logic [7:0] read_data;
	logic       tx_valid;
	logic [7:0] tx_byte;

	versatile_interface_adapter #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.register_select(register_select),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.read_data(read_data),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte)
	);

	// Predicted adapter state
	logic [7:0]  pb_out = '0;
	logic [7:0]  pa_out = '0;
	logic [7:0]  plain_regs [16] = '{default: '0};
	logic [15:0] t1_count = '0;
	logic [15:0] t1_latch = '0;
	logic [15:0] t2_count = '0;
	logic [15:0] t2_latch = '0;
	logic [7:0]  irq_flags = '0;
	logic [6:0]  irq_enable = '0;
	logic [7:0]  shift_data = '0;
	logic [3:0]  shift_steps_left = '0;
	logic        shift_busy = 1'b0;
	logic        rx_byte_ready = 1'b0;
	logic [7:0]  rx_queue [FIFO_DEPTH];
	int          rx_head = 0;
	int          rx_tail = 0;

	bus_result_t bus_results_due [$];

	int mismatch_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int tx_seen = 0;
	int chars_dropped = 0;
	int input_stalls = 0;
	int cycle_count = 0;
	int source_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_requested = 1'b0;

	function automatic bus_result_t compute_bus_result(logic [2:0] op, logic [3:0] rs,
			logic [7:0] d);
		bus_result_t res;
		int head_after;
		res = '0;
		case (op)
			OP_READ: begin
				case (rs)
					RS_PORT_B: res.read_data = {pb_out[7], rx_head != rx_tail, pb_out[5:0]};
					RS_PORT_A: begin
						if (rx_head != rx_tail) begin
							res.read_data = rx_queue[rx_tail];
							rx_tail = (rx_tail + 1) % FIFO_DEPTH;
						end else begin
							res.read_data = pa_out;
						end
					end
					RS_T1_LO, RS_T1_HI, RS_T2_LO, RS_T2_HI: res.read_data = '0;
					RS_SR: begin
						if (rx_byte_ready) begin
							rx_byte_ready = 1'b0;
							irq_flags = irq_flags & ~FLAG_SR;
							res.read_data = shift_data;
						end
					end
					RS_IFR: res.read_data = irq_flags;
					RS_IER: res.read_data = {1'b1, irq_enable};
					default: res.read_data = plain_regs[rs];
				endcase
			end
			OP_WRITE: begin
				case (rs)
					RS_PORT_B: begin
						if (d[7]) begin
							res.tx_valid = 1'b1;
							res.tx_byte = pa_out;
						end
						pb_out = d;
					end
					RS_PORT_A: pa_out = d;
					RS_T1_LO: t1_latch[7:0] = d;
					RS_T1_HI: begin
						t1_latch[15:8] = d;
						t1_count = t1_latch;
					end
					RS_T2_LO: t2_latch[7:0] = d;
					RS_T2_HI: begin
						t2_latch[15:8] = d;
						t2_count = t2_latch;
					end
					RS_SR: begin
						shift_data = d;
						shift_steps_left = SHIFT_STEPS;
						shift_busy = 1'b1;
						irq_flags = irq_flags & ~FLAG_SR;
					end
					RS_IFR: irq_flags = irq_flags & ~d;
					RS_IER: begin
						if (d[7])
							irq_enable = irq_enable | d[6:0];
						else
							irq_enable = irq_enable & ~d[6:0];
					end
					default: plain_regs[rs] = d;
				endcase
			end
			OP_TICK: begin
				if (t1_count != 0) begin
					t1_count = t1_count - 16'd1;
					if (t1_count == 0)
						irq_flags = irq_flags | FLAG_T1;
				end
				if (t2_count != 0) begin
					t2_count = t2_count - 16'd1;
					if (t2_count == 0)
						irq_flags = irq_flags | FLAG_T2;
				end
				if (shift_busy) begin
					shift_data = shift_data << 1;
					shift_steps_left = shift_steps_left - 4'd1;
					if (shift_steps_left == 0) begin
						shift_busy = 1'b0;
						irq_flags = irq_flags | FLAG_SR;
					end
				end
			end
			OP_SERIAL: begin
				head_after = (rx_head + 1) % FIFO_DEPTH;
				if (head_after != rx_tail) begin
					rx_queue[rx_head] = d;
					rx_head = head_after;
				end else begin
					chars_dropped++;
				end
			end
			OP_SHIFT_RX: begin
				shift_data = d;
				rx_byte_ready = 1'b1;
				irq_flags = irq_flags | FLAG_SR;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] %s: got %02h, want %02h (result %0d)", $time, what, got, want,
				results_checked);
		mismatch_count++;
	endtask

	// Offer one item, hold it until the transfer, then predict its result.
	task automatic send_item(logic [2:0] op, logic [3:0] rs, logic [7:0] d,
			bit use_fixed = 1'b0, bus_result_t fixed_result = '0);
		bus_result_t predicted;
		while ($urandom_range(0, 99) < source_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		register_select <= rs;
		data_byte <= d;
		@(posedge clk);
		while (item_stall !== 1'b0) begin
			input_stalls++;
			@(posedge clk);
		end
		predicted = compute_bus_result(op, rs, d);
		bus_results_due.push_back(use_fixed ? fixed_result : predicted);
		if (op <= OP_SHIFT_RX)
			items_sent++;
	endtask

	task automatic run_random(int quota);
		int stop_at;
		int n;
		logic [3:0] lo_reg;
		logic [3:0] hi_reg;
		logic [3:0] rs;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: begin
					// program a timer, mostly short enough to expire
					if ($urandom_range(0, 1)) begin
						lo_reg = RS_T2_LO;
						hi_reg = RS_T2_HI;
					end else begin
						lo_reg = RS_T1_LO;
						hi_reg = RS_T1_HI;
					end
					send_item(OP_WRITE, lo_reg,
						($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
					send_item(OP_WRITE, hi_reg,
						($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
					repeat ($urandom_range(0, 8)) send_item(OP_TICK, 4'($urandom), 8'($urandom));
					send_item(OP_READ, ($urandom_range(0, 3) == 0) ? lo_reg : RS_IFR, 8'($urandom));
					send_item(OP_WRITE, RS_IFR, 8'($urandom));
				end
				1: begin
					send_item(OP_WRITE, RS_SR, 8'($urandom));
					if ($urandom_range(0, 2) == 0)
						send_item(OP_SHIFT_RX, 4'($urandom), 8'($urandom));
					repeat ($urandom_range(5, 10)) send_item(OP_TICK, 4'($urandom), 8'($urandom));
					send_item(OP_READ, RS_IFR, 8'($urandom));
					send_item(OP_READ, RS_SR, 8'($urandom));
				end
				2: begin
					send_item(OP_SHIFT_RX, 4'($urandom), 8'($urandom));
					if ($urandom_range(0, 1))
						send_item(OP_TICK, 4'($urandom), 8'($urandom));
					send_item(OP_READ, RS_SR, 8'($urandom));
					send_item(OP_READ, RS_SR, 8'($urandom));
				end
				3: begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
					repeat (n) send_item(OP_SERIAL, 4'($urandom), 8'($urandom));
					send_item(OP_READ, RS_PORT_B, 8'($urandom));
					repeat ($urandom_range(1, n + 2)) send_item(OP_READ, RS_PORT_A, 8'($urandom));
				end
				4: begin
					send_item(OP_WRITE, RS_PORT_A, 8'($urandom));
					send_item(OP_WRITE, RS_PORT_B, 8'($urandom));
				end
				5: begin
					send_item(OP_WRITE, RS_IER, 8'($urandom));
					send_item(OP_READ, RS_IER, 8'($urandom));
				end
				6: begin
					rs = 4'($urandom);
					send_item(OP_WRITE, rs, 8'($urandom));
					send_item(OP_READ, rs, 8'($urandom));
				end
				default: send_item(3'($urandom), 4'($urandom), 8'($urandom));
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: check each transfer, stall at random or for one long stretch on request.
	initial begin
		bus_result_t want;
		int hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
				if (bus_results_due.size() == 0) begin
					note_mismatch("result with nothing pending", read_data, 8'h00);
				end else begin
					want = bus_results_due.pop_front();
					results_checked++;
					if (tx_valid === 1'b1)
						tx_seen++;
					if (read_data !== want.read_data)
						note_mismatch("read_data", read_data, want.read_data);
					if (tx_valid !== want.tx_valid)
						note_mismatch("tx_valid", 8'(tx_valid), 8'(want.tx_valid));
					if (tx_byte !== want.tx_byte)
						note_mismatch("tx_byte", tx_byte, want.tx_byte);
				end
			end
			if (hold_requested) begin
				hold_requested = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		opcode = '0;
		register_select = '0;
		data_byte = '0;
		source_idle_pct = 35;
		sink_stall_pct = 54;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].rs, DIRECTED_ROWS[i].data,
				DIRECTED_ROWS[i].fixed,
				{DIRECTED_ROWS[i].read_data, DIRECTED_ROWS[i].tx_valid, DIRECTED_ROWS[i].tx_byte});
		run_random(210);

		source_idle_pct = 54;
		sink_stall_pct = 35;
		run_random(210);

		// hold results back while overfilling the rx queue, then drain it past empty
		source_idle_pct = 0;
		sink_stall_pct = 0;
		hold_requested = 1'b1;
		repeat (70) send_item(OP_SERIAL, 4'($urandom), 8'($urandom));
		repeat (66) send_item(OP_READ, RS_PORT_A, 8'($urandom));
		run_random(100);
		item_valid <= 1'b0;

		while (bus_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d bus items, %0d results checked, %0d bytes transmitted",
			items_sent, results_checked, tx_seen);
		$display("%0d serial chars dropped on a full queue, input held back for %0d cycles",
			chars_dropped, input_stalls);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/vif_pkg.sv
rtl/vif_ram.sv
rtl/versatile_interface_adapter.sv
tb/sv/tb_versatile_interface_adapter.sv
